[design/itp_pkg.sv]
// shared types, codes and defaults of the infix to postfix converter
`default_nettype none
package itp_pkg;

  // default sizing
  localparam int StackDepthDef = 32;
  localparam int FuncIdBitsDef = 4;

  // incoming token kinds
  localparam logic [3:0] TK_OPERAND = 4'd0;
  localparam logic [3:0] TK_LPAREN  = 4'd1;
  localparam logic [3:0] TK_RPAREN  = 4'd2;
  localparam logic [3:0] TK_FUNC    = 4'd3;
  localparam logic [3:0] TK_POW     = 4'd4;
  localparam logic [3:0] TK_MUL     = 4'd5;
  localparam logic [3:0] TK_DIV     = 4'd6;
  localparam logic [3:0] TK_PLUS    = 4'd7;
  localparam logic [3:0] TK_MINUS   = 4'd8;
  localparam logic [3:0] TK_END     = 4'd9;

  // stack entry kinds, also the result kinds (operand shares code zero with lparen)
  localparam logic [2:0] OK_LPAREN  = 3'd0;
  localparam logic [2:0] OK_OPERAND = 3'd0;
  localparam logic [2:0] OK_FUNC    = 3'd1;
  localparam logic [2:0] OK_POW     = 3'd2;
  localparam logic [2:0] OK_MUL     = 3'd3;
  localparam logic [2:0] OK_DIV     = 3'd4;
  localparam logic [2:0] OK_PLUS    = 3'd5;
  localparam logic [2:0] OK_MINUS   = 3'd6;
  localparam logic [2:0] OK_UMINUS  = 3'd7;

  // pop masks, one bit per stack entry kind
  localparam logic [7:0] MASK_NONE   = 8'h00;
  localparam logic [7:0] MASK_FUNC   = 8'h02;
  localparam logic [7:0] MASK_POW    = 8'h06;
  localparam logic [7:0] MASK_MULDIV = 8'h1E;
  localparam logic [7:0] MASK_ALL    = 8'hFE;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_LPAREN = 3'd1;
  localparam logic [2:0] ERR_NO_RPAREN = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  // one result before its last-of-run flag is known
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [2:0]  err;
  } result_t;

  // sequencer to emit stage
  typedef struct packed {
    logic    gen;
    logic    flush;
    result_t item;
  } emit_ctrl_t;

endpackage
`default_nettype wire

[design/itp_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module itp_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[design/itp_emit.sv]
// result holding stage: keeps the latest result until its last-of-run flag is known
`default_nettype none
module itp_emit
  import itp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire emit_ctrl_t  ctrl,
  output logic             ready,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_value,
  output logic [2:0]       out_error_code,
  output logic             out_last_of_run
);

  logic    pend_valid_r;
  result_t pend_r;
  logic    out_valid_r;
  result_t out_item_r;
  logic    out_last_r;
  logic    out_free;

  // the output register can take a new transaction
  assign out_free = !out_valid_r || !out_stall;
  assign ready    = !pend_valid_r || out_free;

  // pending slot and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (ctrl.gen && ready) begin
      if (pend_valid_r) begin
        out_item_r  <= pend_r;
        out_last_r  <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
      pend_r       <= ctrl.item;
      pend_valid_r <= 1'b1;
    end else if (ctrl.flush && ready && pend_valid_r) begin
      out_item_r   <= pend_r;
      out_last_r   <= 1'b1;
      out_valid_r  <= 1'b1;
      pend_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_item_r.kind;
  assign out_value       = out_item_r.value;
  assign out_error_code  = out_item_r.err;
  assign out_last_of_run = out_last_r;

endmodule
`default_nettype wire

[design/infix_to_postfix_converter.sv]
// infix to postfix converter: token sequencer around the operator stack
//
// Takes one pre-classified token per input transaction (in_valid / in_stall)
// and produces its postfix results on the output channel (out_valid /
// out_stall), the final result of each token flagged by out_last_of_run.
// in_stall is high while a token is being worked on; the next token is
// taken once the previous one has finished, even if its last result still
// waits in the output register.
// Steps per token: accept, then for stack operators one stack read per
// popped entry plus one for the entry that ends the pop run, then push or
// check, then release the last result. Operands and errors on unknown
// tokens are accepted and released without reading the stack; a unary
// plus is only accepted. The pop loop is paced by the registered read of
// the stack ram. Each result waits in a pending slot and moves to the
// output register once the next result, or the end of the token, is
// known. A stall on the output holds the current result and freezes the
// sequencer whenever it has a further result to pass on.
// Reset (rst_n low, synchronous) empties the stack, drops any pending or
// output result and expects an operand; the stack ram itself is not cleared.
`default_nettype none
module infix_to_postfix_converter
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH  = StackDepthDef,
  parameter int FUNC_ID_BITS = FuncIdBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_token_kind,
  input  wire logic [31:0] in_token_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_value,
  output logic [2:0]       out_error_code,
  output logic             out_last_of_run
);

  localparam int EW = 3 + FUNC_ID_BITS;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_FIN,
    S_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    ACT_PUSH,
    ACT_RPAREN,
    ACT_END
  } act_t;

  state_t                  state_r;
  logic [CW-1:0]           count_r;
  logic                    expect_r;
  logic [7:0]              mask_r;
  act_t                    act_r;
  logic [2:0]              push_kind_r;
  logic [FUNC_ID_BITS-1:0] push_func_r;

  logic [CW-1:0]           count_m1;
  logic [EW-1:0]           rd_data;
  logic [2:0]              top_kind;
  logic [FUNC_ID_BITS-1:0] top_func;
  logic                    top_pops;
  logic                    stack_full;
  logic                    wr_en;
  emit_ctrl_t              ectrl;
  logic                    emit_ready;
  logic                    accept;

  // stack ram, read address always follows the top of stack
  assign count_m1 = count_r - CW'(1);

  itp_ram #(
    .Width(EW),
    .Depth(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count_r[AW-1:0]),
    .wr_data({push_func_r, push_kind_r}),
    .rd_addr(count_m1[AW-1:0]),
    .rd_data(rd_data)
  );

  // top entry decode and pop decision
  assign top_kind   = rd_data[2:0];
  assign top_func   = rd_data[EW-1:3];
  assign top_pops   = (count_r != '0) && mask_r[top_kind];
  assign stack_full = (count_r == CW'(STACK_DEPTH));
  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign wr_en      = (state_r == S_FIN) && (act_r == ACT_PUSH) && !stack_full;

  // results handed to the emit stage
  always_comb begin
    ectrl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_token_kind == TK_OPERAND) begin
            ectrl.gen  = 1'b1;
            ectrl.item = '{kind: OK_OPERAND, value: in_token_value, err: ERR_NONE};
          end else if (in_token_kind > TK_END) begin
            ectrl.gen  = 1'b1;
            ectrl.item = '{kind: OK_OPERAND, value: 32'd0, err: ERR_UNKNOWN};
          end
        end
      end
      S_CHK: begin
        if (top_pops) begin
          ectrl.gen        = 1'b1;
          ectrl.item.kind  = top_kind;
          ectrl.item.value = (top_kind == OK_FUNC) ? 32'(top_func) : 32'd0;
          ectrl.item.err   = ERR_NONE;
        end
      end
      S_FIN: begin
        ectrl.item.kind  = OK_OPERAND;
        ectrl.item.value = 32'd0;
        unique case (act_r)
          ACT_PUSH: begin
            ectrl.gen      = stack_full;
            ectrl.item.err = ERR_OVERFLOW;
          end
          ACT_RPAREN: begin
            ectrl.gen      = (count_r == '0);
            ectrl.item.err = ERR_NO_LPAREN;
          end
          ACT_END: begin
            ectrl.gen      = (count_r != '0);
            ectrl.item.err = ERR_NO_RPAREN;
          end
          default: begin
            ectrl.gen = 1'b0;
          end
        endcase
      end
      S_FLUSH: begin
        ectrl.flush = 1'b1;
      end
      default: begin
        ectrl = '0;
      end
    endcase
  end

  itp_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ectrl),
    .ready          (emit_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .out_error_code (out_error_code),
    .out_last_of_run(out_last_of_run)
  );

  // token sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      expect_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            push_func_r <= (in_token_kind == TK_FUNC) ?
                           in_token_value[FUNC_ID_BITS-1:0] : '0;
            unique case (in_token_kind)
              TK_OPERAND: begin
                expect_r <= 1'b0;
                state_r  <= S_FLUSH;
              end
              TK_LPAREN: begin
                mask_r      <= MASK_NONE;
                act_r       <= ACT_PUSH;
                push_kind_r <= OK_LPAREN;
                state_r     <= S_RD;
              end
              TK_RPAREN: begin
                mask_r  <= MASK_ALL;
                act_r   <= ACT_RPAREN;
                state_r <= S_RD;
              end
              TK_FUNC: begin
                mask_r      <= MASK_FUNC;
                act_r       <= ACT_PUSH;
                push_kind_r <= OK_FUNC;
                state_r     <= S_RD;
              end
              TK_POW: begin
                mask_r      <= MASK_POW;
                act_r       <= ACT_PUSH;
                push_kind_r <= OK_POW;
                state_r     <= S_RD;
              end
              TK_MUL, TK_DIV: begin
                mask_r      <= MASK_MULDIV;
                act_r       <= ACT_PUSH;
                push_kind_r <= (in_token_kind == TK_MUL) ? OK_MUL : OK_DIV;
                state_r     <= S_RD;
              end
              TK_PLUS, TK_MINUS: begin
                act_r <= ACT_PUSH;
                if (!expect_r) begin
                  // binary plus or minus
                  mask_r      <= MASK_ALL;
                  push_kind_r <= (in_token_kind == TK_PLUS) ? OK_PLUS : OK_MINUS;
                  state_r     <= S_RD;
                end else if (in_token_kind == TK_MINUS) begin
                  // unary minus pushes without popping
                  mask_r      <= MASK_NONE;
                  push_kind_r <= OK_UMINUS;
                  state_r     <= S_RD;
                end
                // unary plus is dropped
              end
              TK_END: begin
                mask_r  <= MASK_ALL;
                act_r   <= ACT_END;
                state_r <= S_RD;
              end
              default: begin
                // unknown token
                count_r  <= '0;
                expect_r <= 1'b1;
                state_r  <= S_FLUSH;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (!top_pops) begin
            state_r <= S_FIN;
          end else if (emit_ready) begin
            count_r <= count_m1;
            state_r <= S_RD;
          end
        end
        S_FIN: begin
          if (!ectrl.gen) begin
            unique case (act_r)
              ACT_PUSH: begin
                count_r  <= count_r + CW'(1);
                expect_r <= 1'b1;
              end
              ACT_RPAREN: begin
                count_r  <= count_m1;
                expect_r <= 1'b0;
              end
              ACT_END: begin
                expect_r <= 1'b1;
              end
              default: begin
                expect_r <= 1'b1;
              end
            endcase
            state_r <= S_FLUSH;
          end else if (emit_ready) begin
            // error result clears the stack
            count_r  <= '0;
            expect_r <= 1'b1;
            state_r  <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (emit_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench of the infix to postfix converter with its own shunting-yard predictor
module testbench;
  import itp_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 250;
  localparam int PRINT_CAP    = 200;

  // kinds outside the defined token set
  localparam logic [3:0] TK_UNKNOWN_LO = 4'd10;
  localparam logic [3:0] TK_UNKNOWN_HI = 4'd15;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic        hold;
  } token_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [2:0]  err;
    logic        last_run;
  } postfix_t;

  typedef struct packed {
    logic [FuncIdBitsDef-1:0] func;
    logic [2:0]               kind;
  } stack_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_token_kind = '0;
  logic [31:0] in_token_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [31:0] out_value;
  logic [2:0]  out_error_code;
  logic        out_last_of_run;

  // stimulus and expected postfix stream
  token_t       token_queue[$];
  postfix_t     postfix_expected[$];
  postfix_t     token_run[$];
  token_t       launch;
  postfix_t     want;
  logic         hold_next = 1'b0;

  // predictor state
  stack_entry_t op_stack [StackDepthDef];
  int           op_depth = 0;
  logic         want_operand = 1'b1;

  int gap_left = 0;
  int stall_left = 0;
  int result_seen = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int quiet_left = 0;
  logic quiet = 1'b0;

  infix_to_postfix_converter uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_token_kind   (in_token_kind),
    .in_token_value  (in_token_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .out_error_code  (out_error_code),
    .out_last_of_run (out_last_of_run)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mismatch reporting
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input int idx, input logic [31:0] got,
                             input logic [31:0] wanted);
    if (got !== wanted)
      report_mismatch($sformatf("result %0d field %s got %h wanted %h", idx, name, got, wanted));
  endtask

  // predictor: operator stack handling
  task automatic add_result(input logic [2:0] kind, input logic [31:0] value,
                            input logic [2:0] err);
    postfix_t r;
    r.kind = kind;
    r.value = value;
    r.err = err;
    r.last_run = 1'b0;
    token_run = {token_run, r};
  endtask

  task automatic raise_error(input logic [2:0] err);
    op_depth = 0;
    want_operand = 1'b1;
    add_result(OK_OPERAND, 32'd0, err);
  endtask

  task automatic pop_matching(input logic [7:0] mask);
    stack_entry_t top;
    while (op_depth > 0) begin
      top = op_stack[op_depth - 1];
      if (!mask[top.kind]) break;
      add_result(top.kind, (top.kind == OK_FUNC) ? 32'(top.func) : 32'd0, ERR_NONE);
      op_depth--;
    end
  endtask

  task automatic push_entry(input logic [2:0] kind, input logic [31:0] func);
    stack_entry_t e;
    if (op_depth >= StackDepthDef) begin
      raise_error(ERR_OVERFLOW);
    end else begin
      e.kind = kind;
      e.func = func[FuncIdBitsDef-1:0];
      op_stack[op_depth] = e;
      op_depth++;
    end
  endtask

  // predictor: one token in, its postfix results appended to the expected stream
  task automatic shunt_token(input logic [3:0] kind, input logic [31:0] value);
    postfix_t r;
    token_run.delete();
    case (kind)
      TK_OPERAND: begin
        add_result(OK_OPERAND, value, ERR_NONE);
        want_operand = 1'b0;
      end
      TK_LPAREN: begin
        push_entry(OK_LPAREN, 32'd0);
        if (token_run.size() == 0) want_operand = 1'b1;
      end
      TK_RPAREN: begin
        pop_matching(MASK_ALL);
        if (op_depth == 0) begin
          raise_error(ERR_NO_LPAREN);
        end else begin
          op_depth--;
          want_operand = 1'b0;
        end
      end
      TK_FUNC: begin
        pop_matching(MASK_FUNC);
        push_entry(OK_FUNC, value);
        want_operand = 1'b1;
      end
      TK_POW: begin
        pop_matching(MASK_POW);
        push_entry(OK_POW, 32'd0);
        want_operand = 1'b1;
      end
      TK_MUL, TK_DIV: begin
        pop_matching(MASK_MULDIV);
        push_entry((kind == TK_MUL) ? OK_MUL : OK_DIV, 32'd0);
        want_operand = 1'b1;
      end
      TK_PLUS, TK_MINUS: begin
        // sign in operand position: minus becomes unary, plus vanishes
        if (want_operand) begin
          if (kind == TK_MINUS) push_entry(OK_UMINUS, 32'd0);
        end else begin
          pop_matching(MASK_ALL);
          push_entry((kind == TK_PLUS) ? OK_PLUS : OK_MINUS, 32'd0);
          want_operand = 1'b1;
        end
      end
      TK_END: begin
        pop_matching(MASK_ALL);
        if (op_depth > 0) raise_error(ERR_NO_RPAREN);
        else want_operand = 1'b1;
      end
      default: begin
        raise_error(ERR_UNKNOWN);
      end
    endcase
    if (token_run.size() > 0) begin
      r = token_run[token_run.size() - 1];
      r.last_run = 1'b1;
      token_run[token_run.size() - 1] = r;
    end
    foreach (token_run[i]) postfix_expected = {postfix_expected, token_run[i]};
  endtask

  // idle length, mostly short with the odd long one
  function automatic int idle_length();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // stimulus builders
  function automatic logic [31:0] operand_value();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_token(input logic [3:0] kind, input logic [31:0] value);
    token_t t;
    t.kind = kind;
    t.value = value;
    t.hold = hold_next || ($urandom_range(0, 59) == 0);
    hold_next = 1'b0;
    token_queue = {token_queue, t};
  endtask

  // well-formed expression with random nesting, signs and functions
  task automatic queue_expression(input int terms);
    int nest;
    int i;
    nest = 0;
    for (i = 0; i < terms; i++) begin
      while ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: begin
            queue_token(TK_LPAREN, $urandom());
            nest++;
          end
          1: begin
            queue_token(TK_FUNC, $urandom());
            queue_token(TK_LPAREN, $urandom());
            nest++;
          end
          2: queue_token(TK_FUNC, $urandom());
          3: queue_token(TK_MINUS, $urandom());
          default: queue_token(TK_PLUS, $urandom());
        endcase
      end
      queue_token(TK_OPERAND, operand_value());
      while (nest > 0 && $urandom_range(0, 2) == 0) begin
        queue_token(TK_RPAREN, $urandom());
        nest--;
      end
      if (i < terms - 1) begin
        case ($urandom_range(0, 4))
          0: queue_token(TK_POW, $urandom());
          1: queue_token(TK_MUL, $urandom());
          2: queue_token(TK_DIV, $urandom());
          3: queue_token(TK_PLUS, $urandom());
          default: queue_token(TK_MINUS, $urandom());
        endcase
      end
    end
    while (nest > 0) begin
      queue_token(TK_RPAREN, $urandom());
      nest--;
    end
    queue_token(TK_END, $urandom());
  endtask

  // arbitrary token kinds, unknown ones included
  task automatic queue_noise(input int len);
    repeat (len) queue_token(4'($urandom_range(0, 15)), $urandom());
    if ($urandom_range(0, 1) == 0) queue_token(TK_END, $urandom());
  endtask

  // long run of pushes that fills the stack and may overflow it
  task automatic queue_deep(input int count, input logic [3:0] kind);
    repeat (count) queue_token(kind, $urandom());
    queue_token(TK_OPERAND, operand_value());
    if (kind == TK_LPAREN) repeat ($urandom_range(0, count)) queue_token(TK_RPAREN, $urandom());
    queue_token(TK_END, $urandom());
  endtask

  // stimulus, reset and end of run
  initial begin
    int r;
    int base;
    // directed: signs in operand position, every operator, extremes of the fields
    queue_token(TK_PLUS, 32'hFFFF_FFFF);
    queue_token(TK_MINUS, 32'h0000_0000);
    queue_token(TK_OPERAND, 32'h0000_0000);
    queue_token(TK_POW, 32'h0000_0000);
    queue_token(TK_OPERAND, 32'hFFFF_FFFF);
    queue_token(TK_MUL, 32'hFFFF_FFFF);
    queue_token(TK_FUNC, 32'hFFFF_FFFF);
    queue_token(TK_LPAREN, 32'h0000_0000);
    queue_token(TK_MINUS, 32'hFFFF_FFFF);
    queue_token(TK_OPERAND, 32'hA5A5_5A5A);
    queue_token(TK_DIV, 32'h0000_0000);
    queue_token(TK_OPERAND, 32'h5A5A_A5A5);
    queue_token(TK_RPAREN, 32'hFFFF_FFFF);
    queue_token(TK_PLUS, 32'h0000_0000);
    queue_token(TK_OPERAND, 32'h0000_0001);
    queue_token(TK_END, 32'hFFFF_FFFF);
    // directed: right paren on an empty stack
    queue_token(TK_RPAREN, 32'h0000_0000);
    // directed: end marker meets an open paren
    queue_token(TK_LPAREN, 32'h0000_0000);
    queue_token(TK_OPERAND, 32'h8000_0000);
    queue_token(TK_END, 32'h0000_0000);
    // directed: right paren after popping with no open paren left
    queue_token(TK_OPERAND, 32'h7FFF_FFFF);
    queue_token(TK_PLUS, 32'h0000_0000);
    queue_token(TK_OPERAND, 32'h0000_0002);
    queue_token(TK_RPAREN, 32'h0000_0000);
    // directed: unknown kinds
    queue_token(TK_UNKNOWN_LO, 32'hFFFF_FFFF);
    queue_token(TK_UNKNOWN_HI, 32'h0000_0000);
    // random part, the first token waits until the directed results are in
    base = token_queue.size();
    hold_next = 1'b1;
    while (token_queue.size() < base + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 76) queue_expression($urandom_range(1, 6));
      else if (r < 90) queue_noise($urandom_range(1, 6));
      else if (r < 95) queue_deep($urandom_range(29, 34), TK_LPAREN);
      else queue_deep($urandom_range(29, 34), TK_MINUS);
    end
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (token_queue.size() != 0 || in_valid) @(posedge clk);
    while (postfix_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("infix_to_postfix_converter regression: pass");
    end else begin
      $display("infix_to_postfix_converter regression: fail");
    end
    $finish;
  end

  // alternate busy stretches with quiet ones where nobody idles
  always @(posedge clk) begin
    if (quiet_left == 0) begin
      quiet <= ~quiet;
      quiet_left <= $urandom_range(50, 300);
    end else begin
      quiet_left <= quiet_left - 1;
    end
  end

  // driver: predicts each accepted transaction, then launches the next token
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      op_depth = 0;
      want_operand = 1'b1;
    end else begin
      if (in_valid && !in_stall) shunt_token(in_token_kind, in_token_value);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (token_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          launch = token_queue[0];
          // held token waits until every pending result has come out
          if (launch.hold && postfix_expected.size() != 0) begin
            in_valid <= 1'b0;
          end else begin
            token_queue.delete(0);
            in_valid <= 1'b1;
            in_token_kind <= launch.kind;
            in_token_value <= launch.value;
            gap_left <= idle_length();
          end
        end
      end
    end
  end

  // monitor: checks each result transaction and drives random output stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (postfix_expected.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing pending: kind %0d value %h err %0d",
                                    result_seen, out_kind, out_value, out_error_code));
        end else begin
          want = postfix_expected.pop_front();
          check_field("kind", result_seen, 32'(out_kind), 32'(want.kind));
          check_field("value", result_seen, out_value, want.value);
          check_field("error_code", result_seen, 32'(out_error_code), 32'(want.err));
          check_field("last_of_run", result_seen, 32'(out_last_of_run), 32'(want.last_run));
        end
        result_seen++;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        stall_left <= idle_length();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // cycle limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("infix_to_postfix_converter regression: fail");
    $finish;
  end

endmodule

[files.f]
design/itp_pkg.sv
design/itp_ram.sv
design/itp_emit.sv
design/infix_to_postfix_converter.sv
tb/sv/testbench.sv
